// File: rtl/cmdtok_pkg.sv
// Package: shared types and constants of the command line tokenizer.
`default_nettype none

package cmdtok_pkg;

	// Parse modes
	typedef enum logic [1:0] {
		MODE_FINISHED = 2'd0,
		MODE_DELIM    = 2'd1,
		MODE_SIMPLE   = 2'd2,
		MODE_QUOTED   = 2'd3
	} mode_t;

	// Byte classes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Register map (word index taken from paddr[2])
	localparam logic REG_MAX_ARGS = 1'b0;
	localparam logic REG_ESCAPE   = 1'b1;

	localparam logic [5:0] MAX_ARGS_RESET = 6'd32;
	localparam logic [7:0] ESCAPE_RESET   = 8'd92;

	// One result transaction
	typedef struct packed {
		logic [7:0] position;
		logic       arg_start;
		logic [8:0] arg_start_position;
		logic       terminate_here;
		logic [5:0] arg_count;
		logic       done_res;
		logic       overflow;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/cmdtok_core.sv
// Tokenizer core: byte classification, parse state and per-byte result.
`default_nettype none

module cmdtok_core #(
	parameter int MAX_LEN  = 256,
	parameter int MAX_ARGS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          character,
	input  logic                new_command,
	input  logic [5:0]          max_args,
	input  logic [7:0]          escape_char,
	output cmdtok_pkg::result_t result
);
	import cmdtok_pkg::*;

	localparam int IDX_W = $clog2(MAX_LEN + 1);

	mode_t            mode_q, mode_e, mode_d;
	logic             esc_q, esc_e, esc_d;
	logic [IDX_W-1:0] idx_q, idx_e, idx_d;
	logic [5:0]       cnt_q, cnt_e, cnt_d;

	logic [7:0]       max_ext;
	logic [7:0]       limit;
	logic [IDX_W+8:0] idx_wide;
	logic [8:0]       pos9;
	logic             is_delim, is_quote, is_esc;
	logic             idle, start, term, done, ovf;
	logic [8:0]       start_pos;

	// Clamp the argument limit to the build-time maximum
	assign max_ext = {2'b00, max_args};
	assign limit   = (max_ext > 8'(MAX_ARGS)) ? 8'(MAX_ARGS) : max_ext;

	// Classify the byte
	assign is_delim = (character == CH_SPACE) || (character == CH_TAB);
	assign is_quote = (character == CH_DQUOTE);
	assign is_esc   = (character == escape_char);

	// Next state and result
	always_comb begin
		mode_e = new_command ? MODE_DELIM : mode_q;
		esc_e  = new_command ? 1'b0 : esc_q;
		idx_e  = new_command ? '0 : idx_q;
		cnt_e  = new_command ? 6'd0 : cnt_q;

		idx_wide  = (IDX_W + 9)'(idx_e);
		pos9      = idx_wide[8:0];
		idle      = 1'b0;
		start     = 1'b0;
		start_pos = 9'd0;
		term      = 1'b0;
		done      = 1'b0;
		ovf       = 1'b0;
		mode_d    = mode_e;
		esc_d     = esc_e;

		if (mode_e == MODE_FINISHED) begin
			idle = 1'b1;
		end else if (idx_e >= IDX_W'(MAX_LEN)) begin
			done   = 1'b1;
			ovf    = 1'b1;
			mode_d = MODE_FINISHED;
		end else if (({2'b00, cnt_e} >= limit) || (character == CH_NUL)) begin
			done   = 1'b1;
			mode_d = MODE_FINISHED;
		end else if (esc_e) begin
			esc_d = 1'b0;
		end else begin
			case (mode_e)
				MODE_DELIM: begin
					if (is_quote) begin
						start     = 1'b1;
						start_pos = pos9 + 9'd1;
						mode_d    = MODE_QUOTED;
					end else if (!is_delim) begin
						start     = 1'b1;
						start_pos = pos9;
						mode_d    = MODE_SIMPLE;
					end
				end
				MODE_SIMPLE: begin
					if (is_delim) begin
						term   = 1'b1;
						mode_d = MODE_DELIM;
					end else if (is_quote) begin
						term      = 1'b1;
						start     = 1'b1;
						start_pos = pos9 + 9'd1;
						mode_d    = MODE_QUOTED;
					end
				end
				MODE_QUOTED: begin
					if (is_quote) begin
						term   = 1'b1;
						mode_d = MODE_DELIM;
					end else if (!is_delim && is_esc) begin
						esc_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		cnt_d = cnt_e + 6'(start);
		if (idle || done) begin
			idx_d = idx_e;
		end else begin
			idx_d = idx_e + IDX_W'(1);
		end
		if (done) begin
			esc_d = 1'b0;
		end

		result.position           = idle ? 8'd0 : pos9[7:0];
		result.arg_start          = start;
		result.arg_start_position = start_pos;
		result.terminate_here     = term;
		result.arg_count          = cnt_d;
		result.done_res           = done;
		result.overflow           = ovf;
	end

	// Advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FINISHED;
			esc_q  <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= 6'd0;
		end else if (step) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			idx_q  <= idx_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/command_line_tokenizer.sv
// Top level: command line tokenizer with stream ports and register port.
// A result is registered in the output register, or in the skid entry while the output register waits.
// Throughput: one byte per cycle while s_tready is high.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset: asynchronous; parser idle until a byte with new_command set.
`default_nettype none

module command_line_tokenizer #(
	parameter int MAX_LEN  = 256,
	parameter int MAX_ARGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tuser,   // [0] new_command
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] position, [8] arg_start, [17:9] arg_start_position,
	// [18] terminate_here, [24:19] arg_count, [25] done_res, [26] overflow
	output logic [31:0] m_tdata,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cmdtok_pkg::*;

	logic [5:0] max_args_val_q;
	logic [7:0] escape_q;
	logic       push, pop, cfg_wr;
	result_t    res_new, out_q, skid_q;
	logic       out_v_q, skid_v_q;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_val_q <= MAX_ARGS_RESET;
			escape_q       <= ESCAPE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_ARGS: max_args_val_q <= pwdata[5:0];
				REG_ESCAPE:   escape_q       <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_ARGS: prdata = {26'd0, max_args_val_q};
			REG_ESCAPE:   prdata = {24'd0, escape_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Transaction strobes
	assign s_tready = !skid_v_q;
	assign push     = s_tvalid && s_tready;
	assign pop      = out_v_q && m_tready;

	cmdtok_core #(
		.MAX_LEN  (MAX_LEN),
		.MAX_ARGS (MAX_ARGS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (push),
		.character   (s_tdata),
		.new_command (s_tuser),
		.max_args    (max_args_val_q),
		.escape_char (escape_q),
		.result      (res_new)
	);

	// Output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload moves without reset
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q.overflow, out_q.done_res, out_q.arg_count,
		out_q.terminate_here, out_q.arg_start_position, out_q.arg_start,
		out_q.position};

`ifndef SYNTHESIS
	// Skid entry is only filled behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid entry valid with empty output register");

	// Overflow always ends parsing
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.overflow) |-> out_q.done_res)
		else $error("overflow without done");

	// An argument cannot start on the byte that ends parsing
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.arg_start) |-> !out_q.done_res)
		else $error("argument start on terminating byte");

	// Input stalls only after a result was held back
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(out_v_q && !m_tready && push))
		else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire
